>>> hdl/tfbe_pkg.sv
// ----------------------------------------------------------------------------
// tfbe_pkg
// Shared constants, payload types and the restoring division step used by
// the TX fragment block estimator.
// ----------------------------------------------------------------------------
package tfbe_pkg;

	// Field widths
	localparam int LEN_W   = 12;
	localparam int FC_W    = 16;
	localparam int THR_W   = 12;
	localparam int BLK_W   = 6;
	localparam int MPDU_W  = 6;

	// Protocol constants
	localparam int SEC_BYTES      = 16;
	localparam int QOS_HDR_BYTES  = 26;
	localparam int THRESH_MIN     = 256;
	localparam int THRESH_RESET   = 2346;
	localparam int MEM_BLOCKS_MAX = 63;
	localparam int BLOCK_BYTES_DEF = 252;

	// Datapath widths: residue holds length plus security bytes, divisor holds
	// a threshold or a block size, quotient covers block sizes down to 64 bytes
	localparam int RES_W  = LEN_W + 1;
	localparam int DIV_W  = THR_W;
	localparam int QUO_W  = 7;
	localparam int FULL_STEPS = RES_W - $clog2(THRESH_MIN);
	localparam int FULL_W = FULL_STEPS;
	localparam int MAX_MPDUS = (2 ** LEN_W - 1 + SEC_BYTES) / THRESH_MIN + 1;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_FRAG_LIMIT = 1'b0;

	// One division lane: running residue, divisor, quotient bits so far
	typedef struct packed {
		logic [RES_W-1:0] r;
		logic [DIV_W-1:0] d;
		logic [QUO_W-1:0] q;
	} lane_t;

	// Per-frame values that ride along the chain
	typedef struct packed {
		logic              split;
		logic              qos;
		logic              no_ack;
		logic [FULL_W-1:0] full;
	} side_t;

	typedef struct packed {
		lane_t a;
		lane_t b;
		side_t side;
	} cell_data_t;

	// One restoring step: try to subtract the divisor at bit position shift
	function automatic lane_t div_step(lane_t l, int unsigned shift);
		logic [RES_W+DIV_W-1:0] dsh;
		logic [RES_W+DIV_W-1:0] rw;
		lane_t                  res;
		dsh = {{RES_W{1'b0}}, l.d} << shift;
		rw  = {{DIV_W{1'b0}}, l.r};
		res = l;
		if (rw >= dsh) begin
			res.r = l.r - dsh[RES_W-1:0];
			res.q = l.q | (QUO_W'(1) << shift);
		end
		return res;
	endfunction

endpackage

>>> hdl/tx_fragment_block_estimator.sv
// ----------------------------------------------------------------------------
// tx_fragment_block_estimator
// Estimates device memory blocks and fragment count of an outgoing frame.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  input     | in_valid / in_ready    | frame_length, frame_control, no_ack
//  output    | out_valid / out_ready  | block_count, mpdu_count, ack_mode,
//            |                        | qos_flag
//  config    | APB psel/penable/...   | frag_limit at address 0
//
//  One transaction per cycle is accepted while the output is not stalled;
//  each result passes through the chain of restoring division cells:
//  five for frame/threshold in parallel with the threshold/block-size steps,
//  then the tail/block-size steps, then the summing output register.
//  Each cell is its own skid point, so bubbles close up under a stall.
//  Reset empties the chain and loads the threshold with 2346.
// ----------------------------------------------------------------------------
module tx_fragment_block_estimator #(
	parameter int BLOCK_BYTES = tfbe_pkg::BLOCK_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tfbe_pkg::LEN_W-1:0]         frame_length,
	input  logic [tfbe_pkg::FC_W-1:0]          frame_control,
	input  logic                               no_ack,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tfbe_pkg::BLK_W-1:0]         block_count,
	output logic [tfbe_pkg::MPDU_W-1:0]        mpdu_count,
	output logic                               ack_mode,
	output logic                               qos_flag,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tfbe_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [tfbe_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tfbe_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	localparam int ResW = tfbe_pkg::RES_W;
	localparam int DivW = tfbe_pkg::DIV_W;
	localparam int ThrW = tfbe_pkg::THR_W;
	localparam int QuoSteps = $clog2((2 ** DivW - 1 + tfbe_pkg::SEC_BYTES
		+ tfbe_pkg::QOS_HDR_BYTES) / BLOCK_BYTES + 1);
	localparam int Phase1Steps = (tfbe_pkg::FULL_STEPS > QuoSteps) ?
		tfbe_pkg::FULL_STEPS : QuoSteps;
	localparam int NumCells = Phase1Steps + QuoSteps;

	logic [ThrW-1:0]      frag_limit_q;
	logic [ThrW-1:0]      thr;
	logic [ResW-1:0]      payload;
	logic                 split;

	tfbe_pkg::cell_data_t head_d;
	tfbe_pkg::cell_data_t chain_d [NumCells+1];
	tfbe_pkg::cell_data_t cell_in [NumCells];
	logic [NumCells:0]    chain_v;
	logic [NumCells:0]    chain_r;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_limit_q <= ThrW'(tfbe_pkg::THRESH_RESET);
		end else if (psel && penable && pwrite &&
				paddr[2] == tfbe_pkg::REG_FRAG_LIMIT) begin
			frag_limit_q <= pwdata[ThrW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == tfbe_pkg::REG_FRAG_LIMIT) begin
			prdata = tfbe_pkg::APB_DATA_W'(frag_limit_q);
		end
	end

	// Clamp threshold, form payload and load both division lanes
	always_comb begin
		thr = (frag_limit_q < ThrW'(tfbe_pkg::THRESH_MIN)) ?
			ThrW'(tfbe_pkg::THRESH_MIN) : frag_limit_q;
		payload = ResW'(frame_length) + ResW'(tfbe_pkg::SEC_BYTES);
		split   = payload > ResW'(thr);

		head_d.a.r = payload;
		// a zero divisor leaves the payload untouched for unsplit frames
		head_d.a.d = split ? thr : '0;
		head_d.a.q = '0;
		head_d.b.r = ResW'(thr) + ResW'(tfbe_pkg::SEC_BYTES + tfbe_pkg::QOS_HDR_BYTES);
		head_d.b.d = DivW'(BLOCK_BYTES);
		head_d.b.q = '0;
		head_d.side.split  = split;
		head_d.side.qos    = frame_control[3] && (frame_control[6] || frame_control[7]);
		head_d.side.no_ack = no_ack;
		head_d.side.full   = '0;
	end

	assign chain_d[0] = head_d;
	assign chain_v[0] = in_valid;
	assign in_ready   = chain_r[0];

	// Divider chain
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		if (i == Phase1Steps) begin : g_remap
			// Save the full-fragment count and restart lane A on the tail bytes
			assign cell_in[i] = '{
				a: '{r: chain_d[i].a.r, d: DivW'(BLOCK_BYTES), q: '0},
				b: chain_d[i].b,
				side: '{split: chain_d[i].side.split, qos: chain_d[i].side.qos,
					no_ack: chain_d[i].side.no_ack,
					full: chain_d[i].side.split ?
						chain_d[i].a.q[tfbe_pkg::FULL_W-1:0] : '0}};
		end else begin : g_pass
			assign cell_in[i] = chain_d[i];
		end

		tfbe_cell #(
			.EN_A   ((i < Phase1Steps) ? (i < tfbe_pkg::FULL_STEPS) : 1'b1),
			.SHIFT_A((i < Phase1Steps) ?
				((i < tfbe_pkg::FULL_STEPS) ? tfbe_pkg::FULL_STEPS - 1 - i : 0) :
				QuoSteps - 1 - (i - Phase1Steps)),
			.EN_B   ((i < QuoSteps)),
			.SHIFT_B((i < QuoSteps) ? QuoSteps - 1 - i : 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_v[i]),
			.in_ready (chain_r[i]),
			.in_data  (cell_in[i]),
			.out_valid(chain_v[i+1]),
			.out_ready(chain_r[i+1]),
			.out_data (chain_d[i+1])
		);
	end

	// Result register
	tfbe_sum u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chain_v[NumCells]),
		.in_ready   (chain_r[NumCells]),
		.in_data    (chain_d[NumCells]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.block_count(block_count),
		.mpdu_count (mpdu_count),
		.ack_mode   (ack_mode),
		.qos_flag   (qos_flag)
	);

endmodule

>>> hdl/tfbe_cell.sv
// ----------------------------------------------------------------------------
// tfbe_cell
// One cell of the divider chain: a restoring step on either or both lanes,
// registered, with a valid/ready hop to the next cell.
// ----------------------------------------------------------------------------
module tfbe_cell #(
	parameter bit EN_A    = 1'b1,
	parameter int SHIFT_A = 0,
	parameter bit EN_B    = 1'b1,
	parameter int SHIFT_B = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tfbe_pkg::cell_data_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tfbe_pkg::cell_data_t out_data
);

	logic                 valid_q;
	tfbe_pkg::cell_data_t data_q;
	tfbe_pkg::cell_data_t data_nx;

	// Take a transaction when empty or when the neighbor drains this cell
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Apply this cell's division steps
	always_comb begin
		data_nx = in_data;
		if (EN_A) begin
			data_nx.a = tfbe_pkg::div_step(in_data.a, SHIFT_A);
		end
		if (EN_B) begin
			data_nx.b = tfbe_pkg::div_step(in_data.b, SHIFT_B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_nx;
		end
	end

endmodule

>>> hdl/tfbe_sum.sv
// ----------------------------------------------------------------------------
// tfbe_sum
// Output stage: combines the quotients into the block and fragment counts
// and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tfbe_sum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tfbe_pkg::cell_data_t          in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tfbe_pkg::BLK_W-1:0]    block_count,
	output logic [tfbe_pkg::MPDU_W-1:0]   mpdu_count,
	output logic                          ack_mode,
	output logic                          qos_flag
);

	localparam int PfW  = tfbe_pkg::QUO_W + 1;
	localparam int PrdW = tfbe_pkg::FULL_W + PfW;
	localparam int SumW = PrdW + 1;

	logic                        valid_q;
	logic [tfbe_pkg::BLK_W-1:0]  blocks_q;
	logic [tfbe_pkg::MPDU_W-1:0] mpdus_q;
	logic                        ack_q;
	logic                        qos_q;

	logic [PfW-1:0]              per_frag;
	logic [PfW-1:0]              mpdus_w;
	logic [PfW-1:0]              extra;
	logic [PrdW-1:0]             prod;
	logic [SumW-1:0]             total;
	logic [tfbe_pkg::BLK_W-1:0]  blocks_nx;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign block_count = blocks_q;
	assign mpdu_count  = mpdus_q;
	assign ack_mode    = ack_q;
	assign qos_flag    = qos_q;

	// Sum full fragments, the tail fragment and the per-fragment overhead, capped at 63
	always_comb begin
		per_frag = PfW'(in_data.b.q) + PfW'(1);
		mpdus_w  = PfW'(in_data.side.full) + PfW'(1);
		prod     = PrdW'(in_data.side.full) * PrdW'(per_frag);
		extra    = '0;
		if (in_data.side.split) begin
			extra = (mpdus_w < per_frag) ? mpdus_w : per_frag;
		end
		total = SumW'(prod) + SumW'(in_data.a.q) + SumW'(1) + SumW'(extra);
		if (total > SumW'(tfbe_pkg::MEM_BLOCKS_MAX)) begin
			blocks_nx = tfbe_pkg::BLK_W'(tfbe_pkg::MEM_BLOCKS_MAX);
		end else begin
			blocks_nx = total[tfbe_pkg::BLK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blocks_q <= blocks_nx;
			mpdus_q  <= tfbe_pkg::MPDU_W'(in_data.side.full) + tfbe_pkg::MPDU_W'(1);
			ack_q    <= in_data.side.no_ack;
			qos_q    <= in_data.side.qos;
		end
	end

endmodule

>>> hdl/tfbe_checker.sv
// ----------------------------------------------------------------------------
// tfbe_checker
// Port-level checks on the result channel and configuration port.
// ----------------------------------------------------------------------------
module tfbe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [tfbe_pkg::BLK_W-1:0]       block_count,
	input logic [tfbe_pkg::MPDU_W-1:0]      mpdu_count,
	input logic                             pready
);

	// Port never inserts wait states
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	// Hold a stalled result's block and fragment counts
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_count)
			&& $stable(mpdu_count))
		else $error("stalled result changed");

	// Fragment count and block count stay in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_count != '0 && mpdu_count != '0
			&& mpdu_count <= tfbe_pkg::MPDU_W'(tfbe_pkg::MAX_MPDUS))
		else $error("result out of range");

	// A fragmented frame always needs more blocks than fragments
	a_frag_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mpdu_count > tfbe_pkg::MPDU_W'(1) |->
			block_count > mpdu_count)
		else $error("block count below fragment count");

endmodule

bind tx_fragment_block_estimator tfbe_checker u_tfbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.block_count(block_count),
	.mpdu_count (mpdu_count),
	.pready     (pready)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the TX fragment block estimator. It starts with a table of directed
// frames over several thresholds, then runs random frames in phases, with the
// threshold rewritten over APB between phases. Each untyped frame is scored
// against an in-line cost predictor, and results are compared in order,
// field by field. Both handshakes idle and stall at random; one phase has no
// gaps and another holds the output off long enough to back the chain up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BLOCK_SIZE       = tfbe_pkg::BLOCK_BYTES_DEF;
	localparam int PIPE_LATENCY     = 11;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_FRAMES    = 1700;
	localparam int PHASES           = 10;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int IDLE_PCT         = 36;
	localparam int DIRECTED_COUNT   = 21;
	localparam logic [tfbe_pkg::APB_ADDR_W-1:0] FRAG_LIMIT_ADDR =
		tfbe_pkg::APB_ADDR_W'(4 * tfbe_pkg::REG_FRAG_LIMIT);

	typedef struct packed {
		logic [tfbe_pkg::BLK_W-1:0]  block_count;
		logic [tfbe_pkg::MPDU_W-1:0] mpdu_count;
		logic                        ack_mode;
		logic                        qos_flag;
	} frame_cost_t;

	typedef struct packed {
		logic [tfbe_pkg::THR_W-1:0] thr;
		logic [tfbe_pkg::LEN_W-1:0] len;
		logic [tfbe_pkg::FC_W-1:0]  fc;
		logic                       na;
		logic                       typed;
		frame_cost_t                cost;
	} frame_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [tfbe_pkg::LEN_W-1:0]      frame_length;
	logic [tfbe_pkg::FC_W-1:0]       frame_control;
	logic                            no_ack;
	logic                            out_valid;
	logic                            out_ready;
	logic [tfbe_pkg::BLK_W-1:0]      block_count;
	logic [tfbe_pkg::MPDU_W-1:0]     mpdu_count;
	logic                            ack_mode;
	logic                            qos_flag;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [tfbe_pkg::APB_ADDR_W-1:0] paddr;
	logic [tfbe_pkg::APB_DATA_W-1:0] pwdata;
	logic [tfbe_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	// Threshold as last written, expected costs in acceptance order
	logic [tfbe_pkg::THR_W-1:0] frag_limit_cfg;
	frame_cost_t      expected_costs[$];
	int               error_count = 0;
	int               cycle_count = 0;
	bit               tx_steady = 0;
	bit               rx_steady = 0;
	bit               hold_off_req = 0;

	// Directed frames: typed costs only where they are plain to see
	frame_row_t directed_rows [DIRECTED_COUNT] = '{
		'{12'd2346, 12'd0,    16'h0000, 1'b0, 1'b1, '{6'd1,  6'd1, 1'b0, 1'b0}},
		'{12'd2346, 12'd0,    16'hFFFF, 1'b1, 1'b1, '{6'd1,  6'd1, 1'b1, 1'b1}},
		'{12'd2346, 12'd4095, 16'h0000, 1'b0, 1'b0, '0},
		'{12'd2346, 12'd2330, 16'h0008, 1'b0, 1'b1, '{6'd10, 6'd1, 1'b0, 1'b0}},
		'{12'd2346, 12'd2331, 16'h0048, 1'b1, 1'b0, '0},
		'{12'd2346, 12'd235,  16'h0088, 1'b0, 1'b1, '{6'd1,  6'd1, 1'b0, 1'b1}},
		'{12'd2346, 12'd236,  16'h00C0, 1'b0, 1'b1, '{6'd2,  6'd1, 1'b0, 1'b0}},
		'{12'd256,  12'd240,  16'hFFF7, 1'b0, 1'b1, '{6'd2,  6'd1, 1'b0, 1'b0}},
		'{12'd256,  12'd241,  16'h0000, 1'b0, 1'b0, '0},
		'{12'd256,  12'd496,  16'h0048, 1'b1, 1'b0, '0},
		'{12'd256,  12'd4095, 16'hFFFF, 1'b1, 1'b0, '0},
		'{12'd0,    12'd496,  16'h0000, 1'b0, 1'b0, '0},
		'{12'd0,    12'd4095, 16'h0088, 1'b0, 1'b0, '0},
		'{12'd0,    12'd240,  16'h0000, 1'b1, 1'b1, '{6'd2,  6'd1, 1'b1, 1'b0}},
		'{12'd255,  12'd241,  16'h0000, 1'b0, 1'b0, '0},
		'{12'd4095, 12'd4079, 16'h0000, 1'b0, 1'b1, '{6'd17, 6'd1, 1'b0, 1'b0}},
		'{12'd4095, 12'd4080, 16'h0000, 1'b0, 1'b0, '0},
		'{12'd4095, 12'd4095, 16'hFFFF, 1'b1, 1'b0, '0},
		'{12'd1024, 12'd2032, 16'h0000, 1'b0, 1'b0, '0},
		'{12'd1024, 12'd0,    16'h0000, 1'b0, 1'b1, '{6'd1,  6'd1, 1'b0, 1'b0}},
		'{12'd2346, 12'd4095, 16'h5555, 1'b1, 1'b0, '0}
	};

	tx_fragment_block_estimator dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Effective threshold: anything below the floor counts as the floor
	function automatic int unsigned effective_threshold();
		return (frag_limit_cfg < tfbe_pkg::THRESH_MIN) ? tfbe_pkg::THRESH_MIN
			: frag_limit_cfg;
	endfunction

	// Block, fragment, ack and QoS cost of one frame at the current threshold
	function automatic frame_cost_t predict_frame_cost(logic [tfbe_pkg::LEN_W-1:0] len,
			logic [tfbe_pkg::FC_W-1:0] fc, logic na);
		int unsigned thr;
		int unsigned payload;
		int unsigned blocks;
		int unsigned per_frag;
		int unsigned mpdus;
		int unsigned full_frags;
		frame_cost_t cost;
		thr      = effective_threshold();
		payload  = len + tfbe_pkg::SEC_BYTES;
		blocks   = 0;
		per_frag = 0;
		mpdus    = 1;
		if (payload > thr) begin
			full_frags = payload / thr;
			per_frag   = (thr + tfbe_pkg::SEC_BYTES + tfbe_pkg::QOS_HDR_BYTES) / BLOCK_SIZE
				+ 1;
			blocks     = full_frags * per_frag;
			payload    = payload - full_frags * thr;
			mpdus      = full_frags + 1;
		end
		// the tail fragment always costs at least one block, even when empty
		blocks = blocks + payload / BLOCK_SIZE + 1;
		if (mpdus > 1)
			blocks = blocks + ((mpdus < per_frag) ? mpdus : per_frag);
		if (blocks > tfbe_pkg::MEM_BLOCKS_MAX)
			blocks = tfbe_pkg::MEM_BLOCKS_MAX;
		cost.block_count = tfbe_pkg::BLK_W'(blocks);
		cost.mpdu_count  = tfbe_pkg::MPDU_W'(mpdus);
		cost.ack_mode    = na;
		cost.qos_flag    = fc[3] && (fc[6] || fc[7]);
		return cost;
	endfunction

	// Random length, biased toward threshold edges and exact multiples
	function automatic logic [tfbe_pkg::LEN_W-1:0] pick_length();
		int thr;
		int len;
		thr = int'(effective_threshold());
		case ($urandom_range(4))
			0: len = int'($urandom_range(4095));
			1: len = int'($urandom_range(300));
			2: len = thr - tfbe_pkg::SEC_BYTES + int'($urandom_range(6)) - 3;
			3: len = int'($urandom_range(1, (4095 + tfbe_pkg::SEC_BYTES) / thr)) * thr
				- tfbe_pkg::SEC_BYTES + int'($urandom_range(2)) - 1;
			default: len = int'($urandom_range(3800, 4095));
		endcase
		if (len < 0)
			len = 0;
		if (len > 4095)
			len = 4095;
		return tfbe_pkg::LEN_W'(len);
	endfunction

	task automatic report_error(string what, logic [7:0] want, logic [7:0] got);
		error_count++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Offer one frame, hold it until accepted, then queue its expected cost
	task automatic send_frame(logic [tfbe_pkg::LEN_W-1:0] len,
			logic [tfbe_pkg::FC_W-1:0] fc, logic na,
			logic typed, frame_cost_t typed_cost);
		if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		frame_length  <= len;
		frame_control <= fc;
		no_ack        <= na;
		do @(posedge clk); while (!in_ready);
		expected_costs.push_back(typed ? typed_cost : predict_frame_cost(len, fc, na));
	endtask

	// Stop offering and let every outstanding frame come out
	task automatic drain_frames();
		in_valid <= 1'b0;
		while (expected_costs.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Write the threshold, then read it back
	task automatic write_threshold(logic [tfbe_pkg::THR_W-1:0] value);
		logic [tfbe_pkg::APB_DATA_W-1:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= FRAG_LIMIT_ADDR;
		pwdata  <= tfbe_pkg::APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		frag_limit_cfg = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== tfbe_pkg::APB_DATA_W'(value)) begin
			error_count++;
			$display("%0t: frag_limit readback: expected %0d, actual %0d",
				$time, value, readback);
		end
	endtask

	// Output side: random stalls, a no-stall phase, and one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_steady)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Score each accepted result against the oldest expectation
	always @(posedge clk) begin
		frame_cost_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_costs.size() == 0) begin
				error_count++;
				$display("%0t: result with no frame pending: expected none, actual %0d/%0d/%0d/%0d",
					$time, block_count, mpdu_count, ack_mode, qos_flag);
			end else begin
				want = expected_costs.pop_front();
				if (block_count !== want.block_count)
					report_error("block_count", 8'(want.block_count), 8'(block_count));
				if (mpdu_count !== want.mpdu_count)
					report_error("mpdu_count", 8'(want.mpdu_count), 8'(mpdu_count));
				if (ack_mode !== want.ack_mode)
					report_error("ack_mode", 8'(want.ack_mode), 8'(ack_mode));
				if (qos_flag !== want.qos_flag)
					report_error("qos_flag", 8'(want.qos_flag), 8'(qos_flag));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random phases, wrap-up
	initial begin
		logic [tfbe_pkg::THR_W-1:0] thr;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		frame_length  <= '0;
		frame_control <= '0;
		no_ack        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		frag_limit_cfg = tfbe_pkg::THR_W'(tfbe_pkg::THRESH_RESET);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, rewriting the threshold when a row asks for another
		foreach (directed_rows[i]) begin
			if (directed_rows[i].thr != frag_limit_cfg) begin
				drain_frames();
				write_threshold(directed_rows[i].thr);
			end
			send_frame(directed_rows[i].len, directed_rows[i].fc, directed_rows[i].na,
				directed_rows[i].typed, directed_rows[i].cost);
		end

		// random phases, each under its own threshold
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_frames();
			case (phase)
				0: thr = tfbe_pkg::THR_W'(tfbe_pkg::THRESH_RESET);
				1: thr = tfbe_pkg::THR_W'(tfbe_pkg::THRESH_MIN);
				2: thr = '1;
				3: thr = '0;
				default: thr = ($urandom_range(1)) ?
					tfbe_pkg::THR_W'($urandom_range(256, 2346))
					: tfbe_pkg::THR_W'($urandom_range(4095));
			endcase
			write_threshold(thr);
			tx_steady = (phase == 4);
			rx_steady = (phase == 4);
			if (phase == 1)
				hold_off_req = 1;
			for (int n = 0; n < RANDOM_FRAMES / PHASES; n++)
				send_frame(pick_length(), tfbe_pkg::FC_W'($urandom), 1'($urandom),
					1'b0, '0);
		end
		tx_steady = 0;
		rx_steady = 0;

		drain_frames();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
